// ===== rtl/qtc_pkg.sv =====
// Shared types and constants for the quadtree tile cover block.
`timescale 1ns / 1ps
package qtc_pkg;

	// Division numerator width: 31-bit offset shifted by up to 15 levels
	localparam int NUM_W = 46;

	// Configuration register indexes
	localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
	localparam logic [2:0] REG_GRID_SIZE   = 3'd2;
	localparam logic [2:0] REG_BOUND_MAX_X = 3'd3;
	localparam logic [2:0] REG_BOUND_MAX_Y = 3'd4;
	localparam logic [2:0] REG_LEVEL_COUNT = 3'd5;

	// Divider job selects
	localparam logic [1:0] DIV_C0 = 2'd0;
	localparam logic [1:0] DIV_R0 = 2'd1;
	localparam logic [1:0] DIV_C1 = 2'd2;
	localparam logic [1:0] DIV_R1 = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LEVEL,
		ST_DIV,
		ST_COUNT,
		ST_MUL,
		ST_TILE,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic       load;
		logic       out_empty;
		logic       out_whole;
		logic       lvl_init;
		logic       lvl_inc;
		logic       div_start;
		logic [1:0] div_sel;
		logic       div_store;
		logic       count_calc;
		logic       mul;
		logic       out_tile;
		logic       advance;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic whole;
		logic lvl_more;
		logic div_done;
		logic out_last;
	} status_t;

endpackage

// ===== rtl/qtc_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module qtc_div import qtc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   num,
	input  logic [30:0]        den,
	output logic [NUM_W-1:0]   quo,
	output logic               done
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [30:0]      rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [31:0]      trial;
	logic             fits;

	// Shift in the next numerator bit and test against the divisor
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			quo_q  <= num;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= fits ? 31'(trial - {1'b0, den}) : trial[30:0];
			quo_q  <= {quo_q[NUM_W-2:0], fits};
			cnt_q  <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// ===== rtl/qtc_ctrl.sv =====
// Sequencer for level search, index divisions and tile emission.
`timescale 1ns / 1ps
module qtc_ctrl import qtc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t     state_q, state_d;
	logic [1:0] sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= DIV_C0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		sel_d    = sel_q;
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.empty) begin
					cmd.out_empty = 1'b1;
					state_d       = ST_SEND;
				end else if (status.whole) begin
					cmd.out_whole = 1'b1;
					state_d       = ST_SEND;
				end else begin
					cmd.lvl_init = 1'b1;
					state_d      = ST_LEVEL;
				end
			end
			ST_LEVEL: begin
				if (status.lvl_more) begin
					cmd.lvl_inc = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_C0;
					sel_d         = DIV_C0;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					cmd.div_store = 1'b1;
					if (sel_q == DIV_R1) begin
						state_d = ST_COUNT;
					end else begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = sel_q + 1'b1;
						sel_d         = sel_q + 1'b1;
					end
				end
			end
			ST_COUNT: begin
				cmd.count_calc = 1'b1;
				state_d        = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_TILE;
			end
			ST_TILE: begin
				cmd.out_tile = 1'b1;
				state_d      = ST_SEND;
			end
			ST_SEND: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (status.out_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = ST_MUL;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/qtc_dp.sv =====
// Datapath: configuration, clamping, level search, indices and tile fields.
`timescale 1ns / 1ps
module qtc_dp import qtc_pkg::*; #(
	parameter int MAX_TILES  = 64,
	parameter int MAX_LEVELS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [30:0]   cfg_data,
	input  logic [127:0]  view,
	input  cmd_t          cmd,
	output status_t       status,
	output logic [175:0]  out_data,
	output logic [1:0]    out_user,
	output logic          out_last
);

	localparam int CW = $clog2(MAX_TILES + 1);

	// Configuration registers
	logic [30:0] origin_x_q, origin_y_q, grid_q, bmx_q, bmy_q;
	logic [4:0]  lc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			grid_q     <= 31'd65536;
			bmx_q      <= 31'd65536;
			bmy_q      <= 31'd65536;
			lc_q       <= 5'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X:    origin_x_q <= cfg_data;
				REG_ORIGIN_Y:    origin_y_q <= cfg_data;
				REG_GRID_SIZE:   grid_q     <= cfg_data;
				REG_BOUND_MAX_X: bmx_q      <= cfg_data;
				REG_BOUND_MAX_Y: bmy_q      <= cfg_data;
				REG_LEVEL_COUNT: lc_q       <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Clamp the viewport to the map on load
	logic signed [31:0] in_lx, in_ly, in_hx, in_hy;
	logic [30:0]        lx_q, ly_q;
	logic signed [31:0] hx_q, hy_q;

	assign in_lx = view[31:0];
	assign in_ly = view[63:32];
	assign in_hx = view[95:64];
	assign in_hy = view[127:96];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lx_q <= (in_lx < $signed({1'b0, origin_x_q})) ? origin_x_q : in_lx[30:0];
			ly_q <= (in_ly < $signed({1'b0, origin_y_q})) ? origin_y_q : in_ly[30:0];
			hx_q <= (in_hx > $signed({1'b0, bmx_q})) ? $signed({1'b0, bmx_q}) : in_hx;
			hy_q <= (in_hy > $signed({1'b0, bmy_q})) ? $signed({1'b0, bmy_q}) : in_hy;
		end
	end

	// Extent tests
	logic signed [32:0] w, h;
	logic [30:0]        size;

	assign w    = $signed({hx_q[31], hx_q}) - $signed({2'b00, lx_q});
	assign h    = $signed({hy_q[31], hy_q}) - $signed({2'b00, ly_q});
	assign size = (w < h) ? w[30:0] : h[30:0];

	assign status.empty = (w <= 33'sd0) || (h <= 33'sd0);
	assign status.whole = size >= grid_q;

	// Level search: one halving per cycle, capped by the level count
	logic [3:0]  lvl_q, lcap;
	logic [30:0] size_q;
	logic [NUM_W-1:0] size_sh;

	always_comb begin
		if (lc_q == 5'd0) begin
			lcap = 4'd0;
		end else if (lc_q > 5'(MAX_LEVELS)) begin
			lcap = 4'(MAX_LEVELS - 1);
		end else begin
			lcap = 4'(lc_q - 5'd1);
		end
	end

	assign size_sh         = {15'd0, size_q} << lvl_q;
	assign status.lvl_more = (lvl_q < lcap) && (size_sh <= {15'd0, grid_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
		end else if (cmd.lvl_init) begin
			lvl_q <= '0;
		end else if (cmd.lvl_inc) begin
			lvl_q <= lvl_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lvl_init) begin
			size_q <= size;
		end
	end

	// Tile index divisions through a shared divider
	logic [14:0]      mask;
	logic [15:0]      tpc;
	logic [30:0]      dividend;
	logic [NUM_W-1:0] num, quo;
	logic [1:0]       dsel_q;
	logic [14:0]      qclamp;
	logic [14:0]      c0_q, r0_q, c1_q, r1_q;

	assign tpc  = 16'd1 << lvl_q;
	assign mask = 15'(tpc - 16'd1);

	always_comb begin
		case (cmd.div_sel)
			DIV_C0:  dividend = 31'(lx_q - origin_x_q);
			DIV_R0:  dividend = 31'(ly_q - origin_y_q);
			DIV_C1:  dividend = 31'(hx_q[30:0] - origin_x_q);
			default: dividend = 31'(hy_q[30:0] - origin_y_q);
		endcase
		num = {15'd0, dividend} << lvl_q;
		if (cmd.div_sel == DIV_C1 || cmd.div_sel == DIV_R1) begin
			num = num - NUM_W'(1);
		end
	end

	qtc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (grid_q),
		.quo    (quo),
		.done   (status.div_done)
	);

	assign qclamp = (quo > {31'd0, mask}) ? mask : quo[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsel_q <= DIV_C0;
		end else if (cmd.div_start) begin
			dsel_q <= cmd.div_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			case (dsel_q)
				DIV_C0:  c0_q <= qclamp;
				DIV_R0:  r0_q <= qclamp;
				DIV_C1:  c1_q <= qclamp;
				default: r1_q <= qclamp;
			endcase
		end
	end

	// Run size, truncation and emission counters
	logic [31:0]   total_q;
	logic [CW-1:0] count, n_q;
	logic          trunc;
	logic [14:0]   i_q, j_q;

	assign trunc = total_q > 32'(MAX_TILES);
	assign count = trunc ? CW'(MAX_TILES) : total_q[CW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.count_calc) begin
			total_q <= (16'(c1_q - c0_q) + 16'd1) * (16'(r1_q - r0_q) + 16'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			n_q <= '0;
		end else if (cmd.count_calc) begin
			i_q <= c0_q;
			j_q <= r0_q;
			n_q <= '0;
		end else if (cmd.advance) begin
			n_q <= n_q + 1'b1;
			if (i_q == c1_q) begin
				i_q <= c0_q;
				j_q <= j_q + 1'b1;
			end else begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	// Corner products, registered before the add
	logic [45:0] px_q, py_q, sx, sy;
	logic [46:0] cx, cy;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			px_q <= 46'(i_q * grid_q);
			py_q <= 46'(j_q * grid_q);
		end
	end

	assign sx = px_q >> lvl_q;
	assign sy = py_q >> lvl_q;
	assign cx = {16'd0, origin_x_q} + {1'b0, sx};
	assign cy = {16'd0, origin_y_q} + {1'b0, sy};

	// Output register
	logic [29:0] o_id_q;
	logic [3:0]  o_lvl_q;
	logic [14:0] o_col_q, o_row_q, o_rft_q;
	logic [30:0] o_mx_q, o_my_q, o_side_q;
	logic        o_last_q, o_trunc_q, o_empty_q;

	always_ff @(posedge clk) begin
		if (cmd.out_empty) begin
			o_id_q    <= '0;
			o_lvl_q   <= '0;
			o_col_q   <= '0;
			o_row_q   <= '0;
			o_rft_q   <= '0;
			o_mx_q    <= '0;
			o_my_q    <= '0;
			o_side_q  <= '0;
			o_last_q  <= 1'b1;
			o_trunc_q <= 1'b0;
			o_empty_q <= 1'b1;
		end else if (cmd.out_whole) begin
			o_id_q    <= '0;
			o_lvl_q   <= '0;
			o_col_q   <= '0;
			o_row_q   <= '0;
			o_rft_q   <= '0;
			o_mx_q    <= origin_x_q;
			o_my_q    <= origin_y_q;
			o_side_q  <= grid_q;
			o_last_q  <= 1'b1;
			o_trunc_q <= 1'b0;
			o_empty_q <= 1'b0;
		end else if (cmd.out_tile) begin
			o_id_q    <= 30'(({15'd0, j_q} << lvl_q) | {15'd0, i_q});
			o_lvl_q   <= lvl_q;
			o_col_q   <= i_q;
			o_row_q   <= j_q;
			o_rft_q   <= mask - j_q;
			o_mx_q    <= (cx > 47'h7FFF_FFFF) ? 31'h7FFF_FFFF : cx[30:0];
			o_my_q    <= (cy > 47'h7FFF_FFFF) ? 31'h7FFF_FFFF : cy[30:0];
			o_side_q  <= grid_q >> lvl_q;
			o_last_q  <= n_q == CW'(count - 1'b1);
			o_trunc_q <= trunc;
			o_empty_q <= 1'b0;
		end
	end

	assign status.out_last = o_last_q;
	assign out_last = o_last_q;
	assign out_user = {o_empty_q, o_trunc_q};
	assign out_data = {4'd0, o_side_q, o_my_q, o_mx_q, o_rft_q, o_row_q, o_col_q,
		o_lvl_q, o_id_q};

endmodule

// ===== rtl/quadtree_tile_cover.sv =====
// Top level of the quadtree tile cover block.
// Usage:
//   Slave stream takes one viewport request per transfer (four signed Q16.16 edges).
//   Master stream returns the covering tiles of that viewport in row-major order,
//   rows from the bottom; tlast marks the final tile of the request.
//   Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once; the user must
//   make them only while the block is idle, as the block itself does not enforce this.
// Timing:
//   An empty or whole-map viewport gives its single tile from the check state after accept.
//   Otherwise the level search runs first (one halving per cycle), then the
//   four tile-index divisions run in turn on one shared bit-serial divider
//   before the first tile; each further tile then passes through the corner
//   multiply, output register and handshake states.
//   One request is in flight at a time: s_tready is high only when idle.
// Reset and stall:
//   arst_n clears the sequencer and loads the register defaults.
//   A stalled receiver holds the output register and the sequence until m_tready.
`timescale 1ns / 1ps
module quadtree_tile_cover import qtc_pkg::*; #(
	parameter int MAX_TILES  = 64,
	parameter int MAX_LEVELS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [30:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// view_min_x, view_min_y, view_max_x, view_max_y
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tile_id, tile_level, tile_col, tile_row, row_from_top, tile_min_x, tile_min_y,
	// tile_side, zero fill
	output logic [175:0] m_tdata,
	// truncated, empty_view
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	cmd_t    cmd;
	status_t status;

	qtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	qtc_dp #(
		.MAX_TILES  (MAX_TILES),
		.MAX_LEVELS (MAX_LEVELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.view      (s_tdata),
		.cmd       (cmd),
		.status    (status),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

// ===== sim/tb_quadtree_tile_cover.sv =====
// Self-checking testbench for the quadtree tile cover block.
`timescale 1ns / 1ps
module tb_quadtree_tile_cover;
	import qtc_pkg::*;

	localparam int TILE_CAP  = 64;
	localparam int LEVEL_CAP = 16;
	localparam longint unsigned MASK31 = 64'h7FFF_FFFF;

	typedef longint unsigned u64_t;

	typedef struct {
		bit [29:0] id;
		bit [3:0]  level;
		bit [14:0] col;
		bit [14:0] row;
		bit [14:0] rft;
		bit [30:0] min_x;
		bit [30:0] min_y;
		bit [30:0] side;
		bit        last;
		bit        trunc;
		bit        empty;
	} tile_t;

	// Map settings mirrored from the register writes, and expected tiles in order
	class tile_scoreboard;
		bit [30:0] org_x, org_y, grid, max_x, max_y;
		bit [4:0]  levels;
		tile_t     pending_tiles[$];
		int        errors, requests, tiles_seen, cut_runs, empty_runs;

		function new();
			org_x = 0; org_y = 0; grid = 31'd65536;
			max_x = 31'd65536; max_y = 31'd65536; levels = 5'd8;
		endfunction

		function void set_reg(logic [2:0] idx, logic [30:0] val);
			case (idx)
				REG_ORIGIN_X:    org_x = val;
				REG_ORIGIN_Y:    org_y = val;
				REG_GRID_SIZE:   grid = val;
				REG_BOUND_MAX_X: max_x = val;
				REG_BOUND_MAX_Y: max_y = val;
				REG_LEVEL_COUNT: levels = val[4:0];
				default: ;
			endcase
		endfunction

		function longint unsigned corner(longint unsigned org, longint unsigned idx,
				longint unsigned g, int unsigned lvl);
			longint unsigned v;
			v = org + ((idx * g) >> lvl);
			return (v > MASK31) ? MASK31 : v;
		endfunction

		// Clamp the viewport, pick the level and queue the covering tiles, up to the tile cap
		function void note_request(logic [127:0] view);
			longint lx, ly, hx, hy, w, h, sz;
			longint unsigned g, q, total, cnt, n;
			int unsigned lvl, lc, tpc, c0, c1, r0, r1, i, j;
			tile_t t;
			requests++;
			lx = $signed(view[31:0]);
			ly = $signed(view[63:32]);
			hx = $signed(view[95:64]);
			hy = $signed(view[127:96]);
			g = grid;
			if (lx < longint'(org_x)) lx = org_x;
			if (ly < longint'(org_y)) ly = org_y;
			if (hx > longint'(max_x)) hx = max_x;
			if (hy > longint'(max_y)) hy = max_y;
			w = hx - lx;
			h = hy - ly;
			t = '{default: 0};
			t.last = 1'b1;
			if (w <= 0 || h <= 0) begin
				t.empty = 1'b1;
				empty_runs++;
				pending_tiles.push_back(t);
				return;
			end
			sz = (w < h) ? w : h;
			if (u64_t'(sz) >= g) begin
				t.min_x = org_x;
				t.min_y = org_y;
				t.side = grid;
				pending_tiles.push_back(t);
				return;
			end
			lvl = 0;
			while (lvl < 31 && ((u64_t'(sz) << lvl) <= g)) lvl++;
			lc = levels;
			if (lc < 1) lc = 1;
			if (lc > LEVEL_CAP) lc = LEVEL_CAP;
			if (lvl > lc - 1) lvl = lc - 1;
			tpc = 1 << lvl;
			// Quotients are cut to 32 bits before the clamp to the grid
			q = (u64_t'(lx - org_x) << lvl) / g;
			c0 = q[31:0];
			q = (u64_t'(ly - org_y) << lvl) / g;
			r0 = q[31:0];
			q = ((u64_t'(hx - org_x) << lvl) - 1) / g;
			c1 = q[31:0];
			q = ((u64_t'(hy - org_y) << lvl) - 1) / g;
			r1 = q[31:0];
			if (c0 > tpc - 1) c0 = tpc - 1;
			if (c1 > tpc - 1) c1 = tpc - 1;
			if (r0 > tpc - 1) r0 = tpc - 1;
			if (r1 > tpc - 1) r1 = tpc - 1;
			total = u64_t'(c1 - c0 + 1) * u64_t'(r1 - r0 + 1);
			cnt = (total > TILE_CAP) ? TILE_CAP : total;
			if (total > TILE_CAP) cut_runs++;
			n = 0;
			for (j = r0; j <= r1 && n < cnt; j++) begin
				for (i = c0; i <= c1 && n < cnt; i++) begin
					t.id = 30'(j * tpc + i);
					t.level = 4'(lvl);
					t.col = 15'(i);
					t.row = 15'(j);
					t.rft = 15'(tpc - j - 1);
					t.min_x = 31'(corner(org_x, i, g, lvl));
					t.min_y = 31'(corner(org_y, j, g, lvl));
					t.side = 31'(g >> lvl);
					t.last = (n == cnt - 1);
					t.trunc = (total > TILE_CAP);
					t.empty = 1'b0;
					pending_tiles.push_back(t);
					n++;
				end
			end
		endfunction

		function void report(string msg);
			errors++;
			$display("[%0t] tile error: %s", $time, msg);
		endfunction

		function void field(string name, longint unsigned exp, longint unsigned act);
			if (exp != act)
				report($sformatf("%s expected 0x%0h got 0x%0h", name, exp, act));
		endfunction

		// Compare one accepted tile with the oldest expected one
		function void check_tile(logic [175:0] d, logic [1:0] u, logic l);
			tile_t e;
			tiles_seen++;
			if (pending_tiles.size() == 0) begin
				report("tile with none expected");
				return;
			end
			e = pending_tiles.pop_front();
			field("tile_id", e.id, d[29:0]);
			field("tile_level", e.level, d[33:30]);
			field("tile_col", e.col, d[48:34]);
			field("tile_row", e.row, d[63:49]);
			field("row_from_top", e.rft, d[78:64]);
			field("tile_min_x", e.min_x, d[109:79]);
			field("tile_min_y", e.min_y, d[140:110]);
			field("tile_side", e.side, d[171:141]);
			field("fill", 0, d[175:172]);
			field("last_tile", e.last, l);
			field("truncated", e.trunc, u[0]);
			field("empty_view", e.empty, u[1]);
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [30:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [175:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	tile_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;

	quadtree_tile_cover u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Check accepted tiles and stall the output at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_tile(m_tdata, m_tuser, m_tlast);
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Write all six map registers on back-to-back cycles
	task automatic set_map(bit [30:0] ox, bit [30:0] oy, bit [30:0] g,
			bit [30:0] bx, bit [30:0] by, bit [4:0] lc);
		logic [30:0] vals[6];
		vals = '{ox, oy, g, bx, by, {26'd0, lc}};
		for (int k = 0; k < 6; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= k[2:0];
			cfg_data <= vals[k];
			@(posedge clk);
			sb.set_reg(k[2:0], vals[k]);
		end
		cfg_we <= 1'b0;
	endtask

	// Offer one viewport request, with a random gap ahead of it
	task automatic send_view(longint lx, longint ly, longint hx, longint hy);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {hy[31:0], hx[31:0], ly[31:0], lx[31:0]};
		do @(posedge clk); while (!s_tready);
		sb.note_request(s_tdata);
	endtask

	// Wait for every expected tile, then let the sequencer settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_tiles.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic longint sat32(longint v);
		if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return -64'sh8000_0000;
		return v;
	endfunction

	// Random viewport: mostly inside the map at a chosen scale, some noise
	task automatic random_view();
		longint span_x, span_y, lx, ly, w, h;
		int mode;
		mode = $urandom_range(9);
		span_x = longint'(sb.max_x) - longint'(sb.org_x) + 1;
		span_y = longint'(sb.max_y) - longint'(sb.org_y) + 1;
		if (span_x < 1) span_x = 1;
		if (span_y < 1) span_y = 1;
		if (mode == 0) begin
			send_view($signed($urandom), $signed($urandom), $signed($urandom),
				$signed($urandom));
		end else if (mode == 1) begin
			lx = longint'(sb.org_x) + $urandom % span_x;
			ly = longint'(sb.org_y) + $urandom % span_y;
			send_view(lx, ly, lx - $urandom_range(0, 3), ly + $urandom_range(0, 9));
		end else begin
			lx = longint'(sb.org_x) + $urandom % span_x - $urandom_range(0, 2000);
			ly = longint'(sb.org_y) + $urandom % span_y - $urandom_range(0, 2000);
			w = (longint'(sb.grid) >> $urandom_range(0, 17)) * $urandom_range(1, 4)
				+ $urandom_range(0, 300);
			h = (longint'(sb.grid) >> $urandom_range(0, 17)) * $urandom_range(1, 4)
				+ $urandom_range(0, 300);
			send_view(sat32(lx), sat32(ly), sat32(lx + w), sat32(ly + h));
		end
	endtask

	initial begin
		int idle_s[5];
		int idle_r[5];
		sb = new();
		idle_s = '{0, 76, 0, 30, 0};
		idle_r = '{0, 0, 76, 30, 0};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ORIGIN_X;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests on the reset map
		send_view(0, 0, 65536, 65536);
		send_view(-64'sh8000_0000, -64'sh8000_0000, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
		send_view(100, 100, 100, 5000);
		send_view(5000, 100, 100, 5000);
		send_view(-9000, -9000, -1, -1);
		send_view(0, 0, 1, 1);
		send_view(65535, 65535, 65536, 65536);
		send_view(0, 0, 32768, 32768);
		send_view(16384, 16384, 49152, 49152);
		send_view(0, 0, 65536, 1024);
		send_view(20000, 30000, 20001, 64'sh7FFF_FFFF);
		drain();

		// Level count below and above its range, then corner saturation
		set_map(31'd0, 31'd0, 31'd65536, 31'd65536, 31'd65536, 5'd0);
		send_view(0, 0, 1000, 1000);
		drain();
		set_map(31'd0, 31'd0, 31'd65536, 31'd65536, 31'd65536, 5'd31);
		send_view(0, 0, 3, 3);
		send_view(65530, 65530, 65536, 65536);
		drain();
		set_map(31'h7FF0_0000, 31'h7000_0000, 31'h4000_0000, 31'h7FFF_FFFF,
			31'h7FFF_FFFF, 5'd16);
		send_view(64'sh7FF8_0000, 64'sh7FFF_0000, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
		send_view(64'sh7FFF_FFF0, 64'sh7FFF_FFF0, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
		drain();

		// Random phases, each on its own map, with an idle pattern taken from the tables
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: set_map(31'h1_0000, 31'h2_0000, 31'h4_0000, 31'h9_0000, 31'hA_0000, 5'd16);
				1: set_map(31'd0, 31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 5'd20);
				2: set_map(31'h7FF0_0000, 31'h7FF0_0000, 31'h0100_0000, 31'h7FFF_FFFF,
					31'h7FFF_FFFF, 5'd1);
				3: set_map(31'($urandom_range(0, 31'h10_0000)),
					31'($urandom_range(0, 31'h10_0000)),
					31'($urandom_range(1, 31'h100_0000)),
					31'($urandom_range(31'h10_0000, 31'h200_0000)),
					31'($urandom_range(31'h10_0000, 31'h200_0000)),
					5'($urandom_range(1, 16)));
				default: set_map(31'd0, 31'd0, 31'd1, 31'd100, 31'd100, 5'd16);
			endcase
			send_idle_pct = idle_s[p];
			recv_stall_pct = idle_r[p];
			repeat (94) random_view();
			drain();
		end

		$display("covered %0d viewport requests, %0d tiles returned", sb.requests,
			sb.tiles_seen);
		$display("%0d cut runs, %0d empty viewports, 8 map settings", sb.cut_runs,
			sb.empty_runs);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
